// File: src/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OccW        = 5;
  localparam int unsigned CapacityDef = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::cell_cmd_t             cmd_i,
  input  logic                           valid_i,
  input  logic signed [spq_pkg::DataW-1:0] new_data_i,
  input  logic signed [spq_pkg::DataW-1:0] new_prio_i,
  input  logic                           left_keep_i,
  input  logic signed [spq_pkg::DataW-1:0] left_data_i,
  input  logic signed [spq_pkg::DataW-1:0] left_prio_i,
  input  logic signed [spq_pkg::DataW-1:0] right_data_i,
  input  logic signed [spq_pkg::DataW-1:0] right_prio_i,
  output logic                           keep_o,
  output logic signed [spq_pkg::DataW-1:0] data_o,
  output logic signed [spq_pkg::DataW-1:0] prio_o
);

  logic signed [spq_pkg::DataW-1:0] data_q, data_d;
  logic signed [spq_pkg::DataW-1:0] prio_q, prio_d;

  assign keep_o = valid_i && (prio_q <= new_prio_i);
  assign data_o = data_q;
  assign prio_o = prio_q;

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (cmd_i.ins && !keep_o) begin
      if (left_keep_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (cmd_i.rem) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

endmodule

// File: src/stable_sorted_priority_queue.sv
// Channel   Direction  Handshake                Payload
// command   in         start_i high, busy_o low opcode_i, in_data_i, in_priority_i
// result    out        done_o strobe, 1 cycle   out_data_o, status_o, occupancy_o
//
// Every transaction's result strobes on done_o in the next cycle.
// busy_o stays low, so a new transaction may start in every cycle.
// Insert and remove are done in one step by the row of CAPACITY cells, each
// comparing its priority with the incoming one and shifting toward its neighbor.
// Reset clears the entry count; the cells hold no reset value.
// The receiver cannot stall; each result is presented for exactly one cycle.
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CapacityDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              opcode_i,
  input  logic signed [spq_pkg::DataW-1:0]  in_data_i,
  input  logic signed [spq_pkg::DataW-1:0]  in_priority_i,
  output logic                              done_o,
  output logic signed [spq_pkg::DataW-1:0]  out_data_o,
  output logic        [1:0]                 status_o,
  output logic        [spq_pkg::OccW-1:0]   occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q, done_d;
  logic signed [spq_pkg::DataW-1:0] out_data_q, out_data_d;
  spq_pkg::status_e status_q, status_d;
  logic [spq_pkg::OccW-1:0] occ_q, occ_d;

  spq_pkg::cell_cmd_t cmd;
  logic is_full, is_empty;

  logic [CAPACITY-1:0] keep;
  logic signed [spq_pkg::DataW-1:0] cell_data [CAPACITY];
  logic signed [spq_pkg::DataW-1:0] cell_prio [CAPACITY];

  assign busy_o   = 1'b0;
  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.ins = start_i && (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_ENQ) && !is_full;
    cmd.rem = start_i && (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_DEQ) && !is_empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                             left_keep;
    logic signed [spq_pkg::DataW-1:0] left_data, left_prio, right_data, right_prio;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_data = cell_data[0];
      assign left_prio = cell_prio[0];
    end else begin : g_inner
      assign left_keep = keep[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (CntW'(i) < count_q),
      .new_data_i   (in_data_i),
      .new_prio_i   (in_priority_i),
      .left_keep_i  (left_keep),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .keep_o       (keep[i]),
      .data_o       (cell_data[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    done_d     = start_i;
    out_data_d = out_data_q;
    status_d   = status_q;
    if (start_i) begin
      out_data_d = '0;
      if (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_ENQ) begin
        if (is_full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          status_d = spq_pkg::ST_ENQUEUED;
          count_d  = count_q + CntW'(1);
        end
      end else begin
        if (is_empty) begin
          status_d   = spq_pkg::ST_EMPTY;
          out_data_d = '1;
        end else begin
          status_d   = spq_pkg::ST_DEQUEUED;
          out_data_d = cell_data[0];
          count_d    = count_q - CntW'(1);
        end
      end
    end
    occ_d = spq_pkg::OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    status_q   <= status_d;
    occ_q      <= occ_d;
  end

  assign done_o      = done_q;
  assign out_data_o  = out_data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW      = spq_pkg::DataW;
  localparam int unsigned OccW       = spq_pkg::OccW;
  localparam int unsigned Cap        = spq_pkg::CapacityDef;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    logic signed [DataW-1:0] data;
    logic signed [DataW-1:0] prio;
  } entry_t;

  typedef struct {
    logic signed [DataW-1:0] data;
    spq_pkg::status_e        status;
    logic        [OccW-1:0]  occ;
  } result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    opcode_i;
  logic signed [DataW-1:0] in_data_i;
  logic signed [DataW-1:0] in_priority_i;
  logic                    done_o;
  logic signed [DataW-1:0] out_data_o;
  logic        [1:0]       status_o;
  logic        [OccW-1:0]  occupancy_o;

  entry_t  sorted_entries[$];
  result_t pending_results[$];

  int errors        = 0;
  int idle_pct      = 0;
  int stall_cycles  = 0;
  int peak_occ      = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  always #4ns clk_i = ~clk_i;

  stable_sorted_priority_queue #(
    .CAPACITY(Cap)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .in_data_i    (in_data_i),
    .in_priority_i(in_priority_i),
    .done_o       (done_o),
    .out_data_o   (out_data_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  function automatic result_t apply_queue_op(logic op, logic signed [DataW-1:0] d,
                                             logic signed [DataW-1:0] p);
    result_t r;
    entry_t  e;
    int      pos;
    r.data   = '0;
    r.status = spq_pkg::ST_ENQUEUED;
    if (op == spq_pkg::OP_ENQ) begin
      if (sorted_entries.size() >= Cap) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= p) pos++;
        e.data = d;
        e.prio = p;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      r.data   = '1;
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.data   = sorted_entries[0].data;
      r.status = spq_pkg::ST_DEQUEUED;
      sorted_entries.delete(0);
    end
    r.occ = OccW'(sorted_entries.size());
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] rand_word(int tie_pct);
    if ($urandom_range(99) < tie_pct) return DataW'($signed($urandom_range(6)) - 3);
    case ($urandom_range(9))
      0:       return {1'b1, {(DataW-1){1'b0}}};
      1:       return {1'b0, {(DataW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result data %0d status %0d occupancy %0d", $realtime,
                   out_data_o, status_o, occupancy_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o !== want.data) begin
            $display("%0t: out_data expected %0d actual %0d", $realtime, want.data, out_data_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, status_o);
            errors++;
          end
          if (occupancy_o !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $realtime, want.occ,
                     occupancy_o);
            errors++;
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        want = apply_queue_op(opcode_i, in_data_i, in_priority_i);
        pending_results.push_back(want);
        status_tally[want.status]++;
        if (want.occ > peak_occ) peak_occ = want.occ;
      end
      if (done_o === 1'b1 || (start_i && busy_o === 1'b0)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic signed [DataW-1:0] d,
                           input logic signed [DataW-1:0] p);
    start_i       <= 1'b1;
    opcode_i      <= op;
    in_data_i     <= d;
    in_priority_i <= p;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_dequeue();
    send_item(spq_pkg::OP_DEQ, '1, '1);
  endtask

  task automatic test_extremes_and_ties();
    send_item(spq_pkg::OP_ENQ, {1'b0, {(DataW-1){1'b1}}}, {1'b0, {(DataW-1){1'b1}}});
    send_item(spq_pkg::OP_ENQ, {1'b1, {(DataW-1){1'b0}}}, {1'b1, {(DataW-1){1'b0}}});
    send_item(spq_pkg::OP_ENQ, '0, '0);
    send_item(spq_pkg::OP_ENQ, '1, '1);
    send_item(spq_pkg::OP_ENQ, 32'sd1, '0);
    send_item(spq_pkg::OP_ENQ, 32'sd2, {1'b1, {(DataW-1){1'b0}}});
    send_item(spq_pkg::OP_DEQ, '0, '0);
    send_item(spq_pkg::OP_DEQ, 32'sh5a5a_a5a5, 32'sha5a5_5a5a);
  endtask

  task automatic test_full_drop();
    while (sorted_entries.size() < Cap) begin
      send_item(spq_pkg::OP_ENQ, $urandom(), rand_word(50));
    end
    send_item(spq_pkg::OP_ENQ, $urandom(), rand_word(50));
    send_item(spq_pkg::OP_DEQ, $urandom(), $urandom());
    send_item(spq_pkg::OP_ENQ, $urandom(), rand_word(50));
    send_item(spq_pkg::OP_ENQ, $urandom(), rand_word(50));
  endtask

  task automatic test_random_traffic(int n, int pct);
    int enq_bias;
    enq_bias = 50;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       enq_bias = 15;
          1:       enq_bias = 50;
          default: enq_bias = 85;
        endcase
      end
      send_item(($urandom_range(99) < enq_bias) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
                rand_word(0), rand_word(40));
    end
    wait_drained();
    idle_pct = 0;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    opcode_i      = spq_pkg::OP_ENQ;
    in_data_i     = '0;
    in_priority_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_extremes_and_ties();
    test_full_drop();
    wait_drained();
    test_random_traffic(170, 8);
    test_random_traffic(170, 84);
    test_random_traffic(170, 0);

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("covered %0d enqueues, %0d dequeues, %0d empty dequeues, %0d full drops",
             status_tally[spq_pkg::ST_ENQUEUED], status_tally[spq_pkg::ST_DEQUEUED],
             status_tally[spq_pkg::ST_EMPTY], status_tally[spq_pkg::ST_FULL]);
    $display("peak occupancy %0d of %0d; sender idle 8, 84 and 0 percent", peak_occ, Cap);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
